// ===== rtl/core/hex_octet_string_decoder_assert.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef HEX_OCTET_STRING_DECODER_ASSERT_SVH
`define HEX_OCTET_STRING_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HOSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hosd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HOSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hosd assertion failed");

`endif

// ===== rtl/core/hosd_pkg.sv =====
package hosd_pkg;

   localparam int CountBits    = 16;  // internal counter width, 8 to 32
   localparam int OutCountBits = 16;  // width of the count fields on the port
   localparam int CharBits     = 8;
   localparam int OctetBits    = 8;
   localparam int StatusBits   = 2;

   typedef logic [CountBits-1:0]    cnt_type;
   typedef logic [OutCountBits-1:0] out_cnt_type;
   typedef logic [CharBits-1:0]     char_type;

   localparam logic [StatusBits-1:0] StOk       = 2'd0;
   localparam logic [StatusBits-1:0] StMissPfx  = 2'd1;
   localparam logic [StatusBits-1:0] StBadCont  = 2'd2;
   localparam logic [StatusBits-1:0] StOverflow = 2'd3;

   localparam logic KindOctet  = 1'b0;
   localparam logic KindStatus = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [OctetBits-1:0]  octet_value;
      logic [StatusBits-1:0] status;
      out_cnt_type           consumed;
      out_cnt_type           octet_count;
      logic                  final_res;
   } rsp_type;

endpackage

// ===== rtl/core/hosd_chan_if.sv =====
interface hosd_req_if;
   logic                     valid;
   logic                     ready;
   logic [hosd_pkg::CharBits-1:0] ch;
   logic                     last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface hosd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic [hosd_pkg::OctetBits-1:0]       octet_value;
   logic [hosd_pkg::StatusBits-1:0]      status;
   logic [hosd_pkg::OutCountBits-1:0]    consumed;
   logic [hosd_pkg::OutCountBits-1:0]    octet_count;
   logic                                 final_res;

   modport source (output valid, output kind, output octet_value, output status,
                   output consumed, output octet_count, output final_res,
                   input ready);
   modport sink   (input valid, input kind, input octet_value, input status,
                   input consumed, input octet_count, input final_res,
                   output ready);
endinterface

// ===== rtl/core/hosd_parse.sv =====
`include "hex_octet_string_decoder_assert.svh"

module hosd_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [hosd_pkg::CharBits-1:0] ch,
   input  logic                         last,
   output logic                         res_valid,
   output hosd_pkg::rsp_type            res
);

   localparam logic [3:0] PhLead  = 4'd0;
   localparam logic [3:0] PhPfx   = 4'd1;
   localparam logic [3:0] PhDig   = 4'd2;
   localparam logic [3:0] PhHalf  = 4'd3;
   localparam logic [3:0] PhTrail = 4'd4;
   localparam logic [3:0] PhBs    = 4'd5;
   localparam logic [3:0] PhCr    = 4'd6;
   localparam logic [3:0] PhCmt   = 4'd7;
   localparam logic [3:0] PhNl    = 4'd8;
   localparam logic [3:0] PhNlc   = 4'd9;

   localparam hosd_pkg::char_type ChNul   = 8'h00;
   localparam hosd_pkg::char_type ChTab   = 8'h09;
   localparam hosd_pkg::char_type ChLf    = 8'h0A;
   localparam hosd_pkg::char_type ChCr    = 8'h0D;
   localparam hosd_pkg::char_type ChSpace = 8'h20;
   localparam hosd_pkg::char_type ChHash  = 8'h23;
   localparam hosd_pkg::char_type ChZero  = 8'h30;
   localparam hosd_pkg::char_type ChX     = 8'h78;
   localparam hosd_pkg::char_type ChBslash = 8'h5C;

   typedef struct packed {
      logic              ovf;
      hosd_pkg::cnt_type value;
   } sat_type;

   function automatic sat_type sat_add(hosd_pkg::cnt_type a, hosd_pkg::cnt_type b);
      logic [hosd_pkg::CountBits:0] s;
      sat_type r;
      s = {1'b0, a} + {1'b0, b};
      if (s[hosd_pkg::CountBits]) begin
         r.ovf   = 1'b1;
         r.value = '1;
      end else begin
         r.ovf   = 1'b0;
         r.value = s[hosd_pkg::CountBits-1:0];
      end
      return r;
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(hosd_pkg::char_type c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      return r;
   endfunction

   logic [3:0]        phase_ff, phase_in;
   logic [3:0]        high_nibble_ff, high_nibble_in;
   hosd_pkg::cnt_type committed_ff, committed_in;
   hosd_pkg::cnt_type tentative_ff, tentative_in;
   hosd_pkg::cnt_type octets_ff, octets_in;
   logic              finished_ff, finished_in;
   logic              ovf_ff, ovf_in;

   logic       term, is_sp;
   logic [4:0] hx;
   sat_type    c1, c2, o1, ct, t1;

   logic                          pair, fin, fin_term, fin_ovf, clear;
   logic [hosd_pkg::StatusBits-1:0] fin_st, st_eff;
   hosd_pkg::cnt_type             fin_cons;

   assign term  = last || (ch == ChNul);
   assign is_sp = (ch == ChSpace) || (ch == ChTab);
   assign hx    = hex_decode(ch);
   assign c1    = sat_add(committed_ff, hosd_pkg::CountBits'(1));
   assign c2    = sat_add(committed_ff, hosd_pkg::CountBits'(2));
   assign o1    = sat_add(octets_ff, hosd_pkg::CountBits'(1));
   assign ct    = sat_add(committed_ff, tentative_ff);
   assign t1    = sat_add(tentative_ff, hosd_pkg::CountBits'(1));

   always_comb begin
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      committed_in   = committed_ff;
      tentative_in   = tentative_ff;
      octets_in      = octets_ff;
      finished_in    = finished_ff;
      ovf_in         = ovf_ff;
      pair     = 1'b0;
      fin      = 1'b0;
      fin_term = term;
      fin_ovf  = 1'b0;
      fin_st   = hosd_pkg::StOk;
      fin_cons = committed_ff;
      st_eff   = hosd_pkg::StOk;
      clear    = 1'b0;
      res_valid = 1'b0;
      res       = '0;

      if (accept) begin
         if (finished_ff) begin
            clear = term;
         end else begin
            unique case (phase_ff) inside
               PhLead: begin
                  if (!term && (is_sp || ch == ChZero)) begin
                     committed_in = c1.value;
                     ovf_in       = ovf_ff | c1.ovf;
                     if (!is_sp) phase_in = PhPfx;
                  end else begin
                     fin    = 1'b1;
                     fin_st = hosd_pkg::StMissPfx;
                  end
               end
               PhPfx: begin
                  if (!term && ch == ChX) begin
                     committed_in = c1.value;
                     ovf_in       = ovf_ff | c1.ovf;
                     phase_in     = PhDig;
                  end else begin
                     fin    = 1'b1;
                     fin_st = hosd_pkg::StMissPfx;
                  end
               end
               PhDig: begin
                  pair = 1'b1;
               end
               PhHalf: begin
                  if (term || !hx[4]) begin
                     fin = 1'b1;
                  end else begin
                     res_valid        = 1'b1;
                     res.kind         = hosd_pkg::KindOctet;
                     res.octet_value  = {high_nibble_ff, hx[3:0]};
                     committed_in     = c2.value;
                     octets_in        = o1.value;
                     ovf_in           = ovf_ff | c2.ovf | o1.ovf;
                     phase_in         = PhDig;
                  end
               end
               PhTrail: begin
                  if (!term && is_sp) begin
                     tentative_in = t1.value;
                     ovf_in       = ovf_ff | t1.ovf;
                  end else begin
                     fin      = 1'b1;
                     fin_cons = ct.value;
                     fin_ovf  = ct.ovf;
                  end
               end
               PhBs: begin
                  if (term) begin
                     fin = 1'b1;
                  end else if (is_sp || ch == ChHash || ch == ChLf || ch == ChCr) begin
                     committed_in = c1.value;
                     ovf_in       = ovf_ff | c1.ovf;
                     if (ch == ChHash) phase_in = PhCmt;
                     else if (ch == ChLf) phase_in = PhNl;
                     else if (ch == ChCr) phase_in = PhCr;
                  end else begin
                     fin    = 1'b1;
                     fin_st = hosd_pkg::StBadCont;
                  end
               end
               PhCr: begin
                  if (!term && ch == ChLf) begin
                     committed_in = c1.value;
                     ovf_in       = ovf_ff | c1.ovf;
                     phase_in     = PhNl;
                  end else begin
                     fin    = 1'b1;
                     fin_st = hosd_pkg::StBadCont;
                  end
               end
               PhCmt: begin
                  if (term) begin
                     fin = 1'b1;
                  end else begin
                     committed_in = c1.value;
                     ovf_in       = ovf_ff | c1.ovf;
                     if (ch == ChLf) phase_in = PhNlc;
                  end
               end
               PhNl, PhNlc: begin
                  // a comment line may only follow a comment line
                  if (!term && (is_sp || (phase_ff == PhNlc && ch == ChHash))) begin
                     committed_in = c1.value;
                     ovf_in       = ovf_ff | c1.ovf;
                     if (!is_sp) phase_in = PhCmt;
                  end else begin
                     pair = 1'b1;
                  end
               end
               default: begin
                  clear = 1'b1;
               end
            endcase

            // point where a new hex pair or a continuation may start
            if (pair) begin
               if (term) begin
                  fin = 1'b1;
               end else if (hx[4]) begin
                  high_nibble_in = hx[3:0];
                  phase_in       = PhHalf;
               end else if (ch == ChBslash) begin
                  committed_in = c1.value;
                  ovf_in       = ovf_ff | c1.ovf;
                  phase_in     = PhBs;
               end else if (is_sp) begin
                  tentative_in = hosd_pkg::CountBits'(1);
                  phase_in     = PhTrail;
               end else begin
                  fin = 1'b1;
               end
            end

            if (fin) begin
               st_eff = fin_st;
               if (fin_st == hosd_pkg::StOk && (ovf_ff || fin_ovf))
                  st_eff = hosd_pkg::StOverflow;
               res_valid       = 1'b1;
               res.kind        = hosd_pkg::KindStatus;
               res.status      = st_eff;
               res.consumed    = (st_eff == hosd_pkg::StMissPfx ||
                                  st_eff == hosd_pkg::StBadCont) ?
                                 '0 : hosd_pkg::OutCountBits'(fin_cons);
               res.octet_count = hosd_pkg::OutCountBits'(octets_ff);
               res.final_res   = 1'b1;
               if (fin_term) clear = 1'b1;
               else finished_in = 1'b1;
            end
         end

         if (clear) begin
            phase_in       = PhLead;
            high_nibble_in = '0;
            committed_in   = '0;
            tentative_in   = '0;
            octets_in      = '0;
            finished_in    = 1'b0;
            ovf_in         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhLead;
         high_nibble_ff <= '0;
         committed_ff   <= '0;
         tentative_ff   <= '0;
         octets_ff      <= '0;
         finished_ff    <= 1'b0;
         ovf_ff         <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         high_nibble_ff <= high_nibble_in;
         committed_ff   <= committed_in;
         tentative_ff   <= tentative_in;
         octets_ff      <= octets_in;
         finished_ff    <= finished_in;
         ovf_ff         <= ovf_in;
      end
   end

   `HOSD_ASSERT_IMPL(a_res_needs_accept, clock, reset, res_valid, accept)
   `HOSD_ASSERT_IMPL(a_quiet_when_finished, clock, reset, finished_ff, !res_valid)
   `HOSD_ASSERT_NEXT(a_final_ends_run, clock, reset, res_valid && res.final_res,
      finished_ff || (phase_ff == PhLead && committed_ff == '0 && octets_ff == '0))
   `HOSD_ASSERT_NEXT(a_octet_back_to_pair, clock, reset, res_valid && !res.final_res,
      phase_ff == PhDig && !finished_ff)

endmodule

// ===== rtl/core/hosd_out_buf.sv =====
`include "hex_octet_string_decoder_assert.svh"

module hosd_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hosd_pkg::rsp_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output hosd_pkg::rsp_type out_data,
   input  logic              out_ready
);

   logic              out_valid_ff, out_valid_in;
   hosd_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   hosd_pkg::rsp_type skid_data_ff, skid_data_in;

   logic take;

   assign take     = out_valid_ff && out_ready;
   assign in_ready = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         // output register is stalled: park the transaction
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `HOSD_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `HOSD_ASSERT_IMPL(a_no_overrun, clock, reset, in_valid, in_ready)
   `HOSD_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !take,
      skid_valid_ff && $stable(skid_data_ff))

endmodule

// ===== rtl/core/hex_octet_string_decoder.sv =====
// Hex octet string decoder.
// req_if carries one ASCII character per transaction (ch) plus last, which
// marks the end of the text; a NUL character ends it as well.
// rsp_if carries results: an octet (kind 0) when the second digit of a hex
// pair arrives, and one final status record (kind 1, final_res 1) per run
// with status, consumed character count and octet count.
// Each request yields at most one result, registered in the output register
// (via the skid register while rsp_if stalls). A request is taken every
// cycle while the result side keeps up; the throughput is one character per
// cycle, set by the parser state update on each accepted character.
// A two-entry output stage (output register plus skid register) lets the
// block park one more result while rsp_if is stalled; req_if.ready drops
// only when both entries hold results.
// After a final record not caused by the end of text, characters up to and
// including the next terminator are dropped without results.
// Synchronous active-high reset returns the parser to the leading-space
// phase with all counts cleared and empties the output stage.
module hex_octet_string_decoder (
   input  logic       clock,
   input  logic       reset,
   hosd_req_if.sink   req_if,
   hosd_rsp_if.source rsp_if
);

   logic              accept;
   logic              res_valid;
   hosd_pkg::rsp_type res;
   logic              buf_ready;
   logic              out_valid;
   hosd_pkg::rsp_type out_data;

   assign req_if.ready = buf_ready;
   assign accept       = req_if.valid && buf_ready;

   hosd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ch        (req_if.ch),
      .last      (req_if.last),
      .res_valid (res_valid),
      .res       (res)
   );

   hosd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (buf_ready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.valid       = out_valid;
   assign rsp_if.kind        = out_data.kind;
   assign rsp_if.octet_value = out_data.octet_value;
   assign rsp_if.status      = out_data.status;
   assign rsp_if.consumed    = out_data.consumed;
   assign rsp_if.octet_count = out_data.octet_count;
   assign rsp_if.final_res   = out_data.final_res;

endmodule
